[design/hpq_pkg.sv]
// Shared types, constants and helpers for the max-heap priority queue.
package hpq_pkg;

    localparam int HEAP_DEPTH = 256;
    localparam int TAG_BITS   = 16;

    localparam int PRIO_W     = 7;
    localparam int TAG_IO_W   = 16;
    localparam int CAP_W      = 9;
    localparam int OCC_W      = 9;
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
    localparam int IDX_W      = CNT_W;
    localparam int LEVELS     = CNT_W;
    localparam int LVL_W      = $clog2(LEVELS);
    localparam int CH_W       = IDX_W + 1;
    localparam int CMP_W      = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_REMOVED  = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic              req_type;
        logic [PRIO_W-1:0] priority_req;
        logic [15:0]       task_tag;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [PRIO_W-1:0] top_priority;
        logic [15:0]       top_tag;
        logic [OCC_W-1:0]  occupancy;
    } res_t;

    typedef struct packed {
        logic [PRIO_W-1:0]   prio;
        logic [TAG_BITS-1:0] tag;
    } entry_t;

    // token handed from one level cell to the next
    typedef struct packed {
        logic             valid;
        logic             op;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] path;
        logic [LVL_W-1:0] rem;
        logic             shifting;
        entry_t           carry;
    } tok_t;

    typedef struct packed {
        logic [IDX_W-1:0] own_addr;
        logic [IDX_W-1:0] child_l;
        logic [IDX_W-1:0] child_r;
    } rd_req_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } wr_req_t;

    // position of the leading one, i.e. the heap level of a 1-based index
    function automatic logic [LVL_W-1:0] msb_pos(input logic [IDX_W-1:0] v);
        logic [LVL_W-1:0] p;
        p = '0;
        for (int k = 0; k < IDX_W; k++) begin
            if (v[k]) begin
                p = LVL_W'(k);
            end
        end
        return p;
    endfunction

endpackage

[design/hpq_ram.sv]
// Simple dual-read, single-write RAM with registered read data.
module hpq_ram #(
    parameter int DW = 8,
    parameter int AW = 4
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr_a,
    output logic [DW-1:0] rdata_a,
    input  logic [AW-1:0] raddr_b,
    output logic [DW-1:0] rdata_b
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

[design/hpq_cell.sv]
// One heap level cell: compare and swap at its level, then pass the token down.
module hpq_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  hpq_pkg::tok_t    tok_in,
    input  logic [hpq_pkg::CNT_W-1:0] count,
    input  hpq_pkg::entry_t  own_data,
    input  hpq_pkg::entry_t  child_l_data,
    input  hpq_pkg::entry_t  child_r_data,
    output hpq_pkg::tok_t    tok_out,
    output hpq_pkg::rd_req_t rd,
    output hpq_pkg::wr_req_t wr,
    output logic             done
);
    import hpq_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_READ = 2'd1;
    localparam logic [1:0] PH_ACT  = 2'd2;

    logic [1:0] ph_reg, ph_next;
    tok_t       tok_reg;

    logic [CH_W-1:0] left_idx, right_idx, big_idx;
    logic            left_ok, right_ok, pick_right, sink, ins_swap;
    entry_t          big_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg <= PH_IDLE;
        end
        else
        begin
            ph_reg <= ph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_in.valid)
        begin
            tok_reg <= tok_in;
        end
    end

    always_comb
    begin
        left_idx   = {tok_reg.idx, 1'b0};
        right_idx  = {tok_reg.idx, 1'b1};
        left_ok    = left_idx <= {1'b0, count};
        right_ok   = right_idx <= {1'b0, count};
        // larger child wins, left on a tie
        pick_right = right_ok && (child_r_data.prio > child_l_data.prio);
        big_idx    = pick_right ? right_idx : left_idx;
        big_data   = pick_right ? child_r_data : child_l_data;
        sink       = left_ok && (tok_reg.carry.prio < big_data.prio);
        // once the new entry has displaced a node, every node below moves down
        ins_swap   = tok_reg.shifting || (tok_reg.carry.prio > own_data.prio);
    end

    always_comb
    begin
        ph_next = ph_reg;
        rd      = '0;
        wr      = '0;
        tok_out = '0;
        done    = 1'b0;
        unique case (ph_reg)
            PH_IDLE:
            begin
                if (tok_in.valid)
                begin
                    ph_next = PH_READ;
                end
            end
            PH_READ:
            begin
                if (tok_reg.op == REQ_INSERT)
                begin
                    rd.own_addr = tok_reg.idx;
                end
                else
                begin
                    rd.child_l = IDX_W'(left_idx);
                    rd.child_r = IDX_W'(right_idx);
                end
                ph_next = PH_ACT;
            end
            PH_ACT:
            begin
                ph_next = PH_IDLE;
                wr.we   = 1'b1;
                wr.addr = tok_reg.idx;
                if (tok_reg.op == REQ_INSERT)
                begin
                    if (tok_reg.rem == '0)
                    begin
                        wr.data = tok_reg.carry;
                        done    = 1'b1;
                    end
                    else
                    begin
                        wr.data          = ins_swap ? tok_reg.carry : own_data;
                        tok_out.valid    = 1'b1;
                        tok_out.op       = REQ_INSERT;
                        tok_out.idx      = {tok_reg.idx[IDX_W-2:0], tok_reg.path[IDX_W-1]};
                        tok_out.path     = tok_reg.path << 1;
                        tok_out.rem      = tok_reg.rem - 1'b1;
                        tok_out.shifting = ins_swap;
                        tok_out.carry    = ins_swap ? own_data : tok_reg.carry;
                    end
                end
                else
                begin
                    if (sink)
                    begin
                        wr.data       = big_data;
                        tok_out.valid = 1'b1;
                        tok_out.op    = REQ_REMOVE;
                        tok_out.idx   = IDX_W'(big_idx);
                        tok_out.carry = tok_reg.carry;
                    end
                    else
                    begin
                        wr.data = tok_reg.carry;
                        done    = 1'b1;
                    end
                end
            end
            default:
            begin
                ph_next = PH_IDLE;
            end
        endcase
    end

endmodule

[design/max_heap_priority_queue.sv]
// Top level of the binary max-heap priority queue: control, levels and result register.
//
// Usage: present a request on req and raise start; it is taken at a rising edge
// with start high and busy low. req_type selects insert or remove of the largest
// entry. One result per request appears on result for exactly one cycle with done
// high; the receiver must take it then, there is no stall.
// The heap is a chain of level cells, one per tree level, each with its own level
// memory. A request's token walks down one level at a time (each cell reads, then
// compares and writes, then passes the token on); refused requests (full, empty)
// answer on the next cycle. One request is worked on at a time; busy is high until
// its result is shown, and the next request may be taken in the cycle its
// predecessor's result is on the ports.
// cfg_we writes cfg_data into the capacity register (reset value 256); the user
// must raise it only while idle, the block does not enforce this. Reset empties the
// queue, capacity to 256; heap memories are not cleared, only occupied slots' data is used.
module max_heap_priority_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  hpq_pkg::req_t             req,
    output logic                      done,
    output hpq_pkg::res_t             result,
    input  logic                      cfg_we,
    input  logic [hpq_pkg::CAP_W-1:0] cfg_data
);
    import hpq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_RUN  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CAP_W-1:0] cap_reg, cap_next;
    logic             done_reg, done_next;
    logic             op_reg, op_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;
    res_t             res_reg, res_next;
    entry_t           root_reg, root_next;

    tok_t             launch;
    logic             fetch;
    logic             full;
    logic [IDX_W-1:0] tgt;
    logic [LVL_W-1:0] tgt_lvl, lvl_n;

    tok_t             tok [LEVELS];
    rd_req_t          rd [LEVELS];
    wr_req_t          wr [LEVELS];
    entry_t           a_data [LEVELS];
    entry_t           b_data [LEVELS];
    logic [LEVELS-1:0] cell_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            cap_reg   <= CAP_W'(256);
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cap_reg   <= cap_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        lvl_reg  <= lvl_next;
        res_reg  <= res_next;
        root_reg <= root_next;
    end

    always_comb
    begin
        full    = ({{(CMP_W-CNT_W){1'b0}}, count_reg} >= {{(CMP_W-CAP_W){1'b0}}, cap_reg})
               || ({{(CMP_W-CNT_W){1'b0}}, count_reg} >= CMP_W'(HEAP_DEPTH));
        tgt     = IDX_W'(count_reg + 1'b1);
        tgt_lvl = msb_pos(tgt);
        lvl_n   = msb_pos(count_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cap_next   = cfg_we ? cfg_data : cap_reg;
        done_next  = 1'b0;
        op_next    = op_reg;
        lvl_next   = lvl_reg;
        res_next   = res_reg;
        root_next  = root_reg;
        launch     = '0;
        fetch      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next = req.req_type;
                    if (req.req_type == REQ_INSERT)
                    begin
                        if (full)
                        begin
                            done_next = 1'b1;
                            res_next  = '{ST_FULL, '0, '0, OCC_W'(count_reg)};
                        end
                        else
                        begin
                            // path bits below the target's leading one steer the walk down
                            launch.valid      = 1'b1;
                            launch.op         = REQ_INSERT;
                            launch.idx        = IDX_W'(1);
                            launch.path       = IDX_W'(tgt << (IDX_W - int'(tgt_lvl)));
                            launch.rem        = tgt_lvl;
                            launch.shifting   = 1'b0;
                            launch.carry.prio = req.priority_req;
                            launch.carry.tag  = TAG_BITS'(req.task_tag);
                            count_next        = CNT_W'(count_reg + 1'b1);
                            state_next        = S_RUN;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            done_next = 1'b1;
                            res_next  = '{ST_EMPTY, '0, '0, '0};
                        end
                        else
                        begin
                            fetch      = 1'b1;
                            lvl_next   = lvl_n;
                            state_next = S_LOAD;
                        end
                    end
                end
            end
            S_LOAD:
            begin
                root_next = a_data[0];
                if (count_reg == CNT_W'(1))
                begin
                    count_next = '0;
                    done_next  = 1'b1;
                    res_next   = '{ST_REMOVED, a_data[0].prio, TAG_IO_W'(a_data[0].tag), '0};
                    state_next = S_IDLE;
                end
                else
                begin
                    // last entry goes to the root and sinks
                    launch.valid = 1'b1;
                    launch.op    = REQ_REMOVE;
                    launch.idx   = IDX_W'(1);
                    launch.carry = b_data[lvl_reg];
                    count_next   = CNT_W'(count_reg - 1'b1);
                    state_next   = S_RUN;
                end
            end
            S_RUN:
            begin
                if (|cell_done)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    if (op_reg == REQ_INSERT)
                    begin
                        res_next = '{ST_INSERTED, '0, '0, OCC_W'(count_reg)};
                    end
                    else
                    begin
                        res_next = '{ST_REMOVED, root_reg.prio, TAG_IO_W'(root_reg.tag),
                                     OCC_W'(count_reg)};
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    for (genvar L = 0; L < LEVELS; L++)
    begin : g_level
        localparam int LVL_SPAN = 2**L;
        localparam int DEP = (LVL_SPAN < HEAP_DEPTH + 1 - LVL_SPAN) ?
                             LVL_SPAN : HEAP_DEPTH + 1 - LVL_SPAN;
        localparam int AW  = (DEP > 1) ? $clog2(DEP) : 1;

        logic [IDX_W-1:0]        addr_a, addr_b, fetch_b;
        logic [$bits(entry_t)-1:0] raw_a, raw_b;
        tok_t                    cell_in;
        entry_t                  cl_data, cr_data;

        assign fetch_b = (fetch && lvl_n == LVL_W'(L)) ? count_reg : '0;

        if (L == 0)
        begin : g_root
            assign addr_a  = rd[0].own_addr | (fetch ? IDX_W'(1) : '0);
            assign addr_b  = fetch_b;
            assign cell_in = launch;
        end
        else
        begin : g_inner
            assign addr_a  = rd[L].own_addr | rd[L-1].child_l;
            assign addr_b  = rd[L-1].child_r | fetch_b;
            assign cell_in = tok[L-1];
        end

        if (L < LEVELS - 1)
        begin : g_kids
            assign cl_data = a_data[L+1];
            assign cr_data = b_data[L+1];
        end
        else
        begin : g_leaf
            assign cl_data = '0;
            assign cr_data = '0;
        end

        hpq_ram #(
            .DW($bits(entry_t)),
            .AW(AW)
        ) u_ram (
            .clk     (clk),
            .we      (wr[L].we),
            .waddr   (wr[L].addr[AW-1:0]),
            .wdata   (wr[L].data),
            .raddr_a (addr_a[AW-1:0]),
            .rdata_a (raw_a),
            .raddr_b (addr_b[AW-1:0]),
            .rdata_b (raw_b)
        );

        assign a_data[L] = raw_a;
        assign b_data[L] = raw_b;

        hpq_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .tok_in       (cell_in),
            .count        (count_reg),
            .own_data     (a_data[L]),
            .child_l_data (cl_data),
            .child_r_data (cr_data),
            .tok_out      (tok[L]),
            .rd           (rd[L]),
            .wr           (wr[L]),
            .done         (cell_done[L])
        );
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {{(CMP_W-CNT_W){1'b0}}, count_reg} <= CMP_W'(HEAP_DEPTH))
        else $error("entry count above heap depth");

    a_one_cell: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cell_done))
        else $error("more than one level cell finished at once");

    a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (|cell_done) |-> (state_reg == S_RUN))
        else $error("level cell finished outside a running request");

    a_insert_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_INSERTED) |-> (result.occupancy != '0))
        else $error("insert reported with empty queue");

    a_remove_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN && op_reg == REQ_REMOVE) |-> (count_reg != '0))
        else $error("sift-down running on an empty heap");

endmodule
